// ----- design/wfba_pkg.sv -----
// Shared constants for the worst-fit block allocator.
// No dependencies; imported by the top level and its checker.
package wfba_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths
  localparam int SLOT_W = 4;
  localparam int SIZE_W = 16;
  localparam int CFG_W  = 5;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

endpackage

// ----- design/worst_fit_block_allocator_unit.sv -----
// Worst-fit block allocator: top level with the scan sequencer and used marks.
// Depends on wfba_pkg and wfba_size_ram.
//
//  channel  | signals                                     | handshake
//  ---------+---------------------------------------------+--------------------------
//  command  | action_i, block_slot_i, amount_i            | taken when start_i & !busy_o
//  result   | granted_o, chosen_block_o                   | result_valid_o, one cycle
//  config   | cfg_wdata_i (block count)                   | written when cfg_we_i
//
// A load item is written when it is taken, and busy_o never rises for it.
// An allocate item holds busy_o while the scan reads the live table entries in
// turn through the single read port of the size RAM, compares each returned
// size and then closes the scan. With a zero count no read is issued and busy_o
// stays high for a single cycle.
// The result appears in the cycle busy_o falls, for exactly one cycle; the
// receiver cannot stall it.
// Reset clears the block count and every used mark; sizes are undefined
// until loaded.
module worst_fit_block_allocator_unit
  import wfba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start_i,
  output logic              busy_o,
  input  logic              action_i,
  input  logic [SLOT_W-1:0] block_slot_i,
  input  logic [SIZE_W-1:0] amount_i,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  // result channel
  output logic              result_valid_o,
  output logic              granted_o,
  output logic [SLOT_W-1:0] chosen_block_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;    // active entries, saturated
  logic [CNT_W-1:0]  iss_q, iss_d;        // next entry to read
  logic              rvalid_q, rvalid_d;  // read data in flight this cycle
  logic [IDX_W-1:0]  ridx_q, ridx_d;      // entry whose size is on rdata
  logic [SIZE_W-1:0] amt_q, amt_d;        // requested size
  logic              found_q, found_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [SIZE_W-1:0] best_size_q, best_size_d;
  logic [MAX_BLOCKS-1:0] used_q, used_d;
  logic              res_vld_q, res_vld_d;
  logic              granted_q, granted_d;
  logic [SLOT_W-1:0] chosen_q, chosen_d;

  logic              accept;
  logic              slot_ok;
  logic              load_we;
  logic              rd_en;
  logic [SIZE_W-1:0] rdata;
  logic              hit;

  assign accept  = start_i && (state_q == ST_IDLE);
  // Drop loads that fall outside the table
  assign slot_ok = (32'(block_slot_i) < 32'(MAX_BLOCKS));
  assign load_we = accept && (action_i == ACT_LOAD) && slot_ok;
  assign rd_en   = (state_q == ST_SCAN) && (iss_q < count_q);

  wfba_size_ram #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_W)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (IDX_W'(block_slot_i)),
    .wdata_i (amount_i),
    .re_i    (rd_en),
    .raddr_i (iss_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Candidate: free and large enough
  assign hit = !used_q[ridx_q] && (rdata >= amt_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    iss_d       = iss_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    amt_d       = amt_q;
    found_d     = found_q;
    best_d      = best_q;
    best_size_d = best_size_q;
    used_d      = used_q;
    res_vld_d   = 1'b0;
    granted_d   = granted_q;
    chosen_d    = chosen_q;

    // Saturate the block count at the table depth
    if (cfg_we_i) begin
      if (32'(cfg_wdata_i) > 32'(MAX_BLOCKS)) begin
        count_d = CNT_W'(MAX_BLOCKS);
      end else begin
        count_d = CNT_W'(cfg_wdata_i);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_ALLOC) begin
            state_d = ST_SCAN;
            iss_d   = '0;
            amt_d   = amount_i;
            found_d = 1'b0;
            best_d  = '0;
          end else if (slot_ok) begin
            // Reload frees the block
            used_d[IDX_W'(block_slot_i)] = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next read
        if (rd_en) begin
          iss_d    = iss_q + CNT_W'(1);
          rvalid_d = 1'b1;
          ridx_d   = iss_q[IDX_W-1:0];
        end
        // Compare the returned size; strictly larger keeps the lowest index on ties
        if (rvalid_q && hit && (!found_q || (rdata > best_size_q))) begin
          found_d     = 1'b1;
          best_d      = ridx_q;
          best_size_d = rdata;
        end
        // Close the scan once every read has been compared
        if (!rd_en && !rvalid_q) begin
          state_d   = ST_IDLE;
          res_vld_d = 1'b1;
          granted_d = found_q;
          chosen_d  = found_q ? SLOT_W'(best_q) : '0;
          if (found_q) begin
            used_d[best_q] = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      iss_q       <= '0;
      rvalid_q    <= 1'b0;
      ridx_q      <= '0;
      amt_q       <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_size_q <= '0;
      used_q      <= '0;
      res_vld_q   <= 1'b0;
      granted_q   <= 1'b0;
      chosen_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      rvalid_q    <= rvalid_d;
      ridx_q      <= ridx_d;
      amt_q       <= amt_d;
      found_q     <= found_d;
      best_q      <= best_d;
      best_size_q <= best_size_d;
      used_q      <= used_d;
      res_vld_q   <= res_vld_d;
      granted_q   <= granted_d;
      chosen_q    <= chosen_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;

endmodule

// ----- design/wfba_size_ram.sv -----
// Simple dual-port synchronous RAM holding the block sizes.
// One write and one read port, registered read data; no dependencies.
module wfba_size_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/wfba_checker.sv -----
// Port-level checker for the worst-fit block allocator, bound to the top level.
// Depends on wfba_pkg and worst_fit_block_allocator_unit.
module wfba_checker
  import wfba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              action_i,
  input logic              result_valid_o,
  input logic              granted_o,
  input logic [SLOT_W-1:0] chosen_block_o
);

  // An allocate item raises busy in the next cycle
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (action_i == ACT_ALLOC) |=> busy_o)
    else $error("allocate item taken without going busy");

  // A load item neither stalls nor answers
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (action_i == ACT_LOAD) |=> !busy_o && !result_valid_o)
    else $error("load item stalled or produced a result");

  // Every end of a scan delivers exactly its result
  a_fall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o)
    else $error("scan ended without a result");

  // Results only appear with the block idle, and never back to back
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o && !$past(result_valid_o))
    else $error("result while busy or repeated");

  // A refusal carries block index zero
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !granted_o |-> (chosen_block_o == '0))
    else $error("refused request with non-zero block index");

endmodule

bind worst_fit_block_allocator_unit wfba_checker u_wfba_checker (.*);

// ----- bench/worst_fit_block_allocator_unit_tb.sv -----
// Self-checking testbench for worst_fit_block_allocator_unit: a directed table, then random items.
// Depends on wfba_pkg and the allocator RTL; expected grants come from an in-bench predictor.
module worst_fit_block_allocator_unit_tb;
  import wfba_pkg::*;

  localparam int RANDOM_ITEMS  = 900;
  // Settle wait: longer than the longest scan, with some headroom.
  localparam int SETTLE_CYCLES = MAX_BLOCKS + 8;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_ALLOC} row_kind_e;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] block;
  } grant_t;

  // One line of the directed script; fixed_grant is used only when typed is set.
  typedef struct packed {
    row_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] value;
    logic              typed;
    grant_t            fixed_grant;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              action_i;
  logic [SLOT_W-1:0] block_slot_i;
  logic [SIZE_W-1:0] amount_i;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              result_valid_o;
  logic              granted_o;
  logic [SLOT_W-1:0] chosen_block_o;

  // Predictor state: block table, used marks and the live block count.
  logic [SIZE_W-1:0] table_size [MAX_BLOCKS];
  logic              table_used [MAX_BLOCKS];
  int unsigned       live_count;

  // Grants still owed by the block, oldest first.
  grant_t            grant_q [$];
  int unsigned       mismatches;
  bit                gaps_on;

  always #1 clk_i = ~clk_i;

  worst_fit_block_allocator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .block_slot_i   (block_slot_i),
    .amount_i       (amount_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o)
  );

  // Pick the largest free block that fits among the live entries, lowest index on a tie,
  // and mark it used. A miss answers with block 0.
  function automatic grant_t allocate_worst_fit(input logic [SIZE_W-1:0] request);
    grant_t            pick;
    logic [SIZE_W-1:0] best_size;
    pick      = '0;
    best_size = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (k < live_count && !table_used[k] && table_size[k] >= request) begin
        if (!pick.granted || table_size[k] > best_size) begin
          pick.granted = 1'b1;
          pick.block   = SLOT_W'(k);
          best_size    = table_size[k];
        end
      end
    end
    if (pick.granted) table_used[pick.block] = 1'b1;
    return pick;
  endfunction

  function automatic row_t mk(input row_kind_e kind, input int slot, input int value,
                              input bit typed = 1'b0, input bit granted = 1'b0,
                              input int block = 0);
    row_t r;
    r.kind                = kind;
    r.slot                = SLOT_W'(slot);
    r.value               = SIZE_W'(value);
    r.typed               = typed;
    r.fixed_grant.granted = granted;
    r.fixed_grant.block   = SLOT_W'(block);
    return r;
  endfunction

  // Drop start, wait for the block to go quiet, then write the block count.
  task automatic write_block_count(input logic [CFG_W-1:0] count);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk_i);
    // A load leaves no trace in the queue; let any scan still running finish too.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_wdata_i <= count;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    live_count = (count > MAX_BLOCKS) ? MAX_BLOCKS : count;
  endtask

  // Present one item, hold it until the block takes it, then update the predictor.
  task automatic issue_item(input row_t r);
    grant_t guess;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    action_i     <= (r.kind == ROW_ALLOC) ? ACT_ALLOC : ACT_LOAD;
    block_slot_i <= r.slot;
    amount_i     <= r.value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (r.kind == ROW_LOAD) begin
      table_size[r.slot] = r.value;
      table_used[r.slot] = 1'b0;
    end else begin
      // Advance the predictor even where the grant is typed into the table.
      guess = allocate_worst_fit(r.value);
      grant_q.push_back(r.typed ? r.fixed_grant : guess);
    end
  endtask

  // Result checker: every strobe must match the oldest owed grant, field by field.
  always @(posedge clk_i) begin : grant_check
    grant_t want;
    if (rst_ni && result_valid_o) begin
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected grant: granted=%0b block=%0d", granted_o, chosen_block_o);
      end else begin
        want = grant_q.pop_front();
        if (granted_o !== want.granted) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("granted mismatch: expected %0b, got %0b", want.granted, granted_o);
        end
        if (chosen_block_o !== want.block) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("chosen_block mismatch: expected %0d, got %0d",
                     want.block, chosen_block_o);
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    row_t              script [$];
    row_t              r;
    logic [CFG_W-1:0]  extreme_counts [5];
    logic [CFG_W-1:0]  count;
    logic [SIZE_W-1:0] amt;
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       dice;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    action_i     = ACT_LOAD;
    block_slot_i = '0;
    amount_i     = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    live_count   = 0;
    mismatches   = 0;
    gaps_on      = 1'b1;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      table_size[k] = '0;
      table_used[k] = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed script. Zero count first: nothing can be granted.
    script.push_back(mk(ROW_CFG,   0, 0));
    script.push_back(mk(ROW_ALLOC, 0, 0, 1'b1, 1'b0, 0));
    // Fill the whole table so that no scan ever reads an unloaded entry.
    script.push_back(mk(ROW_LOAD,  0, 100));
    script.push_back(mk(ROW_LOAD,  1, 16'hFFFF));
    script.push_back(mk(ROW_LOAD,  2, 0));
    script.push_back(mk(ROW_LOAD,  3, 16'hFFFF));
    script.push_back(mk(ROW_LOAD,  4, 16'h8000));
    script.push_back(mk(ROW_LOAD,  5, 16'h7FFF));
    script.push_back(mk(ROW_LOAD,  6, 16'h5555));
    script.push_back(mk(ROW_LOAD,  7, 16'hAAAA));
    script.push_back(mk(ROW_LOAD,  8, 1));
    script.push_back(mk(ROW_LOAD,  9, 2));
    script.push_back(mk(ROW_LOAD, 10, 16'h0100));
    script.push_back(mk(ROW_LOAD, 11, 16'h00FF));
    script.push_back(mk(ROW_LOAD, 12, 16'h1234));
    script.push_back(mk(ROW_LOAD, 13, 16'hFFFE));
    script.push_back(mk(ROW_LOAD, 14, 16'h4000));
    script.push_back(mk(ROW_LOAD, 15, 16'hFFFF));
    // Two live entries: slot 3 is stored but lies beyond the count.
    script.push_back(mk(ROW_CFG,   0, 2));
    script.push_back(mk(ROW_ALLOC, 0, 16'hFFFF, 1'b1, 1'b1, 1));
    script.push_back(mk(ROW_ALLOC, 0, 16'hFFFF, 1'b1, 1'b0, 0));
    script.push_back(mk(ROW_ALLOC, 0, 0,        1'b1, 1'b1, 0));
    script.push_back(mk(ROW_ALLOC, 0, 0,        1'b1, 1'b0, 0));
    // Oversized count saturates to the full table; ties go to the lowest index.
    script.push_back(mk(ROW_CFG,   0, 31));
    script.push_back(mk(ROW_ALLOC, 15, 16'hFFFF, 1'b1, 1'b1, 3));
    // Reloading a used block frees it again.
    script.push_back(mk(ROW_LOAD,  1, 16'hFFFF));
    script.push_back(mk(ROW_ALLOC, 7, 16'hFFFF, 1'b1, 1'b1, 1));
    script.push_back(mk(ROW_ALLOC, 0, 16'hFFFF, 1'b1, 1'b1, 15));
    script.push_back(mk(ROW_ALLOC, 0, 16'hFFFF, 1'b1, 1'b0, 0));
    script.push_back(mk(ROW_ALLOC, 0, 1));
    script.push_back(mk(ROW_CFG,   0, 1));
    script.push_back(mk(ROW_ALLOC, 0, 0, 1'b1, 1'b0, 0));

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) write_block_count(CFG_W'(script[i].value));
      else issue_item(script[i]);
    end

    // Random phases: the first few counts are the extremes, the rest anything the port takes.
    extreme_counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17};
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      count = (phase < 5) ? extreme_counts[phase] : CFG_W'($urandom_range(0, 31));
      write_block_count(count);
      repeat ($urandom_range(30, 80)) begin
        // Keep one long stretch free of gaps.
        gaps_on = (sent < 350 || sent >= 550);
        dice = $urandom_range(0, 99);
        if (dice < 40) begin
          // Loads: coarse sizes make ties likely, with the extremes thrown in.
          dice = $urandom_range(0, 99);
          if (dice < 50)      amt = SIZE_W'($urandom_range(0, 15) * 256);
          else if (dice < 80) amt = SIZE_W'($urandom_range(0, 65535));
          else if (dice < 90) amt = '1;
          else                amt = '0;
          r = mk(ROW_LOAD, $urandom_range(0, 15), amt);
        end else begin
          // Requests: aim at stored sizes and their neighbours to hit the fit boundary.
          dice = $urandom_range(0, 99);
          if (dice < 30)      amt = table_size[$urandom_range(0, MAX_BLOCKS - 1)];
          else if (dice < 45) amt = table_size[$urandom_range(0, MAX_BLOCKS - 1)] + 1'b1;
          else if (dice < 55) amt = '0;
          else if (dice < 85) amt = SIZE_W'($urandom_range(0, 15) * 256);
          else                amt = SIZE_W'($urandom_range(0, 65535));
          r = mk(ROW_ALLOC, $urandom_range(0, 15), amt);
        end
        issue_item(r);
        sent++;
      end
      phase++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/wfba_pkg.sv
design/wfba_size_ram.sv
design/worst_fit_block_allocator_unit.sv
design/wfba_checker.sv
bench/worst_fit_block_allocator_unit_tb.sv
